// File: hw/rtl/adc_trimmed_mean_filter_defines.svh
// Assertion macros for the trimmed-mean filter.
// Included by the top level; uses no other file.
`ifndef ADC_TRIMMED_MEAN_FILTER_DEFINES_SVH
`define ADC_TRIMMED_MEAN_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ATMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ATMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/atmf_pkg.sv
// Shared types and constants of the trimmed-mean filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package atmf_pkg;

    // Field widths.
    localparam int RAW_W      = 16;
    localparam int SAMPLE_W   = 12;
    localparam int QUOT_W     = 12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the request: write the sample, clear sums
        logic rd_en;     // read the next window entry
        logic trim;      // remove max and min, register the trimmed sum
        logic div_step;  // form the quotient by reciprocal multiplication
        logic load_out;  // move the quotient into the output register
    } t_atmf_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last; // the last window entry is being read
        logic out_free;  // the output register can take a result
    } t_atmf_sts;

endpackage

// File: hw/rtl/adc_trimmed_mean_filter.sv
// Trimmed-mean moving filter for converter samples.
// Input channel: i_valid / o_stall with i_raw_sample; a request is taken when
// i_valid is high and o_stall is low. Only bits 11..0 of the sample are kept.
// Output channel: o_valid / i_stall with o_filtered_value and o_window_ready;
// a result is taken when o_valid is high and i_stall is low.
// Each request writes the ring, then the ring is read one entry per cycle
// (one memory read port) to form sum, max and min, and the trimmed sum is
// divided by one multiplication with the divisor's reciprocal. A new request
// is taken only once the last result has been loaded into the output register.
// The output register lets the next request start while a result waits.
// If the receiver stalls, the next finished result waits in the datapath and
// the block takes no new request until the output register is free.
// Reset (synchronous, active low) empties the ring: entries not yet written
// read as zero, the ready flag is low, and no result is pending.
// Depends on atmf_pkg, atmf_ctrl, atmf_dp and the assertion macro header.
`include "adc_trimmed_mean_filter_defines.svh"

module adc_trimmed_mean_filter
    import atmf_pkg::*;
#(
    parameter int WINDOW_LEN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [RAW_W-1:0]  i_raw_sample,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [QUOT_W-1:0] o_filtered_value,
    output logic              o_window_ready
);

    t_atmf_cmd cmd;
    t_atmf_sts sts;

    // Sequencer.
    atmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Ring, scan, divider and output register.
    atmf_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_raw_sample     (i_raw_sample),
        .i_out_stall      (i_stall),
        .o_valid          (o_valid),
        .o_filtered_value (o_filtered_value),
        .o_window_ready   (o_window_ready)
    );

    // A taken request keeps the block busy in the next cycle.
    `ATMF_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "request taken while busy")

    // A result is loaded only when the output register can take it.
    `ATMF_ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, cmd.load_out, sts.out_free, "result overwrites a pending result")

    // The ready flag never drops between results once it is set.
    `ATMF_ASSERT_NEXT(a_ready_sticky, i_clk, i_rst_n, o_valid && o_window_ready, !o_valid || o_window_ready, "window ready flag dropped")

endmodule

// File: hw/rtl/atmf_ctrl.sv
// Controller state machine of the trimmed-mean filter.
// Depends on atmf_pkg; drives the datapath by command signals.
module atmf_ctrl
    import atmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_atmf_sts i_sts,
    output t_atmf_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_TRIM  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_stall        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_TRIM;
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/atmf_dp.sv
// Datapath of the trimmed-mean filter: sample ring, scan unit, divider, output register.
// Depends on atmf_pkg; controlled by atmf_ctrl through command and status structs.
module atmf_dp
    import atmf_pkg::*;
#(
    parameter int WINDOW_LEN = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_atmf_cmd           i_cmd,
    output t_atmf_sts           o_sts,
    input  logic [RAW_W-1:0]    i_raw_sample,
    input  logic                i_out_stall,
    output logic                o_valid,
    output logic [QUOT_W-1:0]   o_filtered_value,
    output logic                o_window_ready
);

    localparam int IDX_W   = $clog2(WINDOW_LEN);
    localparam int SUM_W   = SAMPLE_W + IDX_W;
    localparam int DIVISOR = WINDOW_LEN - 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

    // Reciprocal of the divisor, rounded up; exact for every sum below 2**SUM_W.
    localparam int DIV_SH  = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_SH) + DIVISOR - 1) / DIVISOR);

    // Sample ring and write side.
    logic [SAMPLE_W-1:0] r_mem [WINDOW_LEN];
    logic [IDX_W-1:0]    r_wr_pos;
    logic                r_filled;
    logic                r_ready;

    // Scan side.
    logic [IDX_W-1:0]    r_rd_addr;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_ok;
    logic                r_rd_vld;
    logic [SUM_W-1:0]    r_total;
    logic [SAMPLE_W-1:0] r_hi;
    logic [SAMPLE_W-1:0] r_lo;

    // Divider.
    logic [SUM_W-1:0]     r_trim;
    logic [QUOT_W-1:0]    r_quot;

    // Output register.
    logic                r_out_valid;
    logic [QUOT_W-1:0]   r_out_value;
    logic                r_out_ready;

    logic [SAMPLE_W-1:0] n_val;
    logic [SUM_W-1:0]    n_trim;
    logic [PROD_W-1:0]   n_prod;

    // Ring write; entries are written in order, so the fill position marks what is valid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wr_pos] <= i_raw_sample[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_filled <= 1'b0;
            r_ready  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_ready <= r_ready | r_filled;
            if (r_wr_pos == LAST_IDX) begin
                r_wr_pos <= '0;
                r_filled <= 1'b1;
            end else begin
                r_wr_pos <= r_wr_pos + 1'b1;
            end
        end
    end

    // Registered ring read; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_addr];
            r_rd_ok   <= r_filled || (r_rd_addr < r_wr_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.accept) begin
                r_rd_addr <= '0;
            end else if (i_cmd.rd_en) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
        end
    end

    assign n_val = r_rd_ok ? r_rd_data : '0;

    // Running sum, maximum and minimum over the window.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_total <= '0;
            r_hi    <= '0;
            r_lo    <= '1;
        end else if (r_rd_vld) begin
            r_total <= r_total + SUM_W'(n_val);
            if (n_val > r_hi) begin
                r_hi <= n_val;
            end
            if (n_val < r_lo) begin
                r_lo <= n_val;
            end
        end
    end

    // Trimmed sum; the max and min are two entries of the sum, so it stays non-negative.
    assign n_trim = r_total - SUM_W'(r_hi) - SUM_W'(r_lo);

    // Division by the constant divisor: multiply by the reciprocal and shift.
    assign n_prod = PROD_W'(r_trim) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.trim) begin
            r_trim <= n_trim;
        end
        if (i_cmd.div_step) begin
            r_quot <= n_prod[DIV_SH +: QUOT_W];
        end
    end

    // Output register holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_quot;
            r_out_ready <= r_ready;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.scan_last = (r_rd_addr == LAST_IDX);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_valid          = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_window_ready   = r_out_ready;

endmodule
